// File: sv/cos_pkg.sv
`timescale 1ns / 1ps

package cos_pkg;

    // command codes carried by an input transaction
    typedef enum logic [1:0] {
        CMD_PERIODIC = 2'd0,
        CMD_SYNC     = 2'd1,
        CMD_QUERY    = 2'd2
    } t_cmd;

    // configuration register indexes
    localparam logic [1:0] CFG_WATCHDOG  = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_SLEW      = 2'd2;

    // configuration reset values
    localparam logic [15:0] WATCHDOG_RST  = 16'd500;
    localparam logic [15:0] THRESHOLD_RST = 16'd50;
    localparam logic [15:0] SLEW_RST      = 16'd1;

    // width of the stamp field on the result channel
    localparam int STAMP_W = 12;

    typedef struct packed {
        logic [15:0] watchdog_timeout_ms;
        logic [15:0] step_threshold_ms;
        logic [15:0] max_slew_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic [62:0] epoch_ms;
        logic        status_ok;
    } t_item;

    typedef struct packed {
        logic               accepted;
        logic               synced;
        logic               time_valid;
        logic [62:0]        logical_ms;
        logic [STAMP_W-1:0] stamp12;
        logic signed [63:0] last_error_ms;
    } t_result;

endpackage

// File: sv/cos_if.sv
`timescale 1ns / 1ps

// input item channel
interface cos_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic [62:0] epoch_ms;
    logic        status_ok;

    modport source (output valid, cmd, now_ms, epoch_ms, status_ok, input ready);
    modport sink   (input valid, cmd, now_ms, epoch_ms, status_ok, output ready);
endinterface

// result channel
interface cos_out_if;
    logic               valid;
    logic               ready;
    logic               accepted;
    logic               synced;
    logic               time_valid;
    logic [62:0]        logical_ms;
    logic [11:0]        stamp12;
    logic signed [63:0] last_error_ms;

    modport source (output valid, accepted, synced, time_valid, logical_ms, stamp12,
                    last_error_ms, input ready);
    modport sink   (input valid, accepted, synced, time_valid, logical_ms, stamp12,
                    last_error_ms, output ready);
endinterface

// configuration write channel
interface cos_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/cos_cfg.sv
`timescale 1ns / 1ps

module cos_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [1:0]    i_wr_index,
    input  logic [15:0]   i_wr_data,
    output cos_pkg::t_cfg o_cfg
);
    import cos_pkg::*;

    t_cfg r_cfg;

    // register file, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.watchdog_timeout_ms <= WATCHDOG_RST;
            r_cfg.step_threshold_ms   <= THRESHOLD_RST;
            r_cfg.max_slew_ms         <= SLEW_RST;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_WATCHDOG:  r_cfg.watchdog_timeout_ms <= i_wr_data;
                CFG_THRESHOLD: r_cfg.step_threshold_ms   <= i_wr_data;
                CFG_SLEW:      r_cfg.max_slew_ms         <= i_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/cos_disc.sv
`timescale 1ns / 1ps

module cos_disc #(
    parameter int STAMP_BITS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  cos_pkg::t_item   i_item,
    input  cos_pkg::t_cfg    i_cfg,
    output cos_pkg::t_result o_res
);
    import cos_pkg::*;

    logic [63:0] r_off_now, n_off_now;
    logic [63:0] r_off_goal, n_off_goal;
    logic [63:0] r_err, n_err;
    logic [31:0] r_good_tick, n_good_tick;
    logic        r_in_sync, n_in_sync;

    logic [63:0] now64, epoch64, base, goal_base, desired, frame_err, err_mag;
    logic [63:0] thr64, slew64, diff_up, diff_dn, logical;
    logic [31:0] elapsed;
    logic        timed_out, off_lt, off_gt, accepted, valid;

    // shared sums and compares
    always_comb begin
        now64     = {32'd0, i_item.now_ms};
        epoch64   = {1'b0, i_item.epoch_ms};
        base      = now64 + r_off_now;
        goal_base = now64 + r_off_goal;
        desired   = epoch64 - now64;
        frame_err = epoch64 - base;
        err_mag   = frame_err[63] ? (64'd0 - frame_err) : frame_err;
        thr64     = {48'd0, i_cfg.step_threshold_ms};
        slew64    = {48'd0, i_cfg.max_slew_ms};
        elapsed   = i_item.now_ms - r_good_tick;
        timed_out = elapsed >= {16'd0, i_cfg.watchdog_timeout_ms};
        off_lt    = $signed(r_off_now) < $signed(r_off_goal);
        off_gt    = $signed(r_off_goal) < $signed(r_off_now);
        diff_up   = r_off_goal - r_off_now;
        diff_dn   = r_off_now - r_off_goal;
    end

    // next state and logical time after the item
    always_comb begin
        n_off_now   = r_off_now;
        n_off_goal  = r_off_goal;
        n_err       = r_err;
        n_good_tick = r_good_tick;
        n_in_sync   = r_in_sync;
        accepted    = 1'b0;
        logical     = base;
        case (i_item.cmd)
            CMD_SYNC: begin
                if (i_item.status_ok) begin
                    accepted    = 1'b1;
                    n_good_tick = i_item.now_ms;
                    n_off_goal  = desired;
                    if (!r_in_sync) begin
                        // first good frame takes the reference as is
                        n_off_now = desired;
                        n_err     = 64'd0;
                        n_in_sync = 1'b1;
                        logical   = epoch64;
                    end else begin
                        n_err = frame_err;
                        if (err_mag > thr64) begin
                            n_off_now = desired;
                            logical   = epoch64;
                        end
                    end
                end else begin
                    n_in_sync = 1'b0;
                end
            end
            CMD_PERIODIC: begin
                if (r_in_sync) begin
                    if (timed_out) begin
                        n_in_sync = 1'b0;
                    end else if (off_lt) begin
                        if (diff_up > slew64) begin
                            n_off_now = r_off_now + slew64;
                            logical   = base + slew64;
                        end else begin
                            n_off_now = r_off_goal;
                            logical   = goal_base;
                        end
                    end else if (off_gt) begin
                        if (diff_dn > slew64) begin
                            n_off_now = r_off_now - slew64;
                            logical   = base - slew64;
                        end else begin
                            n_off_now = r_off_goal;
                            logical   = goal_base;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // result fields
    always_comb begin
        valid               = n_in_sync && !logical[63];
        o_res.accepted      = accepted;
        o_res.synced        = n_in_sync;
        o_res.time_valid    = valid;
        o_res.logical_ms    = valid ? logical[62:0] : 63'd0;
        o_res.last_error_ms = $signed(n_err);
        for (int k = 0; k < STAMP_W; k++) begin
            o_res.stamp12[k] = valid && (k < STAMP_BITS) && logical[k];
        end
    end

    // discipline state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_now   <= 64'd0;
            r_off_goal  <= 64'd0;
            r_err       <= 64'd0;
            r_good_tick <= 32'd0;
            r_in_sync   <= 1'b0;
        end else if (i_en) begin
            r_off_now   <= n_off_now;
            r_off_goal  <= n_off_goal;
            r_err       <= n_err;
            r_good_tick <= n_good_tick;
            r_in_sync   <= n_in_sync;
        end
    end

endmodule

// File: sv/clock_offset_step_slew_sync.sv
`timescale 1ns / 1ps

// channel   dir  handshake     payload
// i_in      in   valid/ready   cmd, now_ms, epoch_ms, status_ok
// o_out     out  valid/ready   accepted, synced, time_valid, logical_ms, stamp12, last_error_ms
// i_cfg     in   valid/ready   index, data (ready always high)
//
// one item per cycle unless o_out stalls; path is input register then result register
// the offset state updates when an item moves from the input register into the result register
// reset (synchronous, active low) clears sync, offsets, error and loads config defaults
// a stalled result holds the result register; the input register still takes one more item if empty

module clock_offset_step_slew_sync #(
    parameter int STAMP_BITS = 12
) (
    input logic      i_clk,
    input logic      i_rst_n,
    cos_in_if.sink   i_in,
    cos_out_if.source o_out,
    cos_cfg_if.sink  i_cfg
);
    import cos_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_res;
    t_result res;
    t_cfg    cfg;
    logic    advance, in_ready;

    assign advance  = !r_out_valid || o_out.ready;
    assign in_ready = !r_in_valid || advance;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    cos_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    // offset discipline
    cos_disc #(
        .STAMP_BITS (STAMP_BITS)
    ) u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_in_valid && advance),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_item.cmd       <= i_in.cmd;
            r_item.now_ms    <= i_in.now_ms;
            r_item.epoch_ms  <= i_in.epoch_ms;
            r_item.status_ok <= i_in.status_ok;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_res <= res;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.accepted      = r_res.accepted;
    assign o_out.synced        = r_res.synced;
    assign o_out.time_valid    = r_res.time_valid;
    assign o_out.logical_ms    = r_res.logical_ms;
    assign o_out.stamp12       = r_res.stamp12;
    assign o_out.last_error_ms = r_res.last_error_ms;

`ifndef ASSERT_OFF
    // an accepted frame always leaves the block synced
    a_accept_synced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.accepted) |-> r_res.synced)
        else $error("accepted frame without sync");

    // valid time needs sync
    a_valid_synced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.time_valid) |-> r_res.synced)
        else $error("time valid while unsynced");

    // invalid time reads as zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.time_valid) |-> (r_res.logical_ms == 63'd0 &&
                                               r_res.stamp12 == '0))
        else $error("invalid time not cleared");

    // both stages full and stalled blocks new input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while pipeline full");

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_in_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule
